@@ design/ttad_pkg.sv @@
// ----------------------------------------------------------------------------
// ttad_pkg
// Shared types, constants and helpers of the two-tap ADPCM block decoder.
// ----------------------------------------------------------------------------
package ttad_pkg;

   // Channel count and field widths
   localparam int CHANNELS   = 8;
   localparam int CHAN_W     = 3;
   localparam int SAMPLE_W   = 16;
   localparam int TAP_W      = 12;
   localparam int NUM_FILT   = 5;
   localparam int TABLE_W    = NUM_FILT * TAP_W;

   // Header low nibble is subtracted from this to get the shift
   localparam logic [3:0] SHIFT_BASE = 4'd12;

   // Input command codes
   typedef enum logic [1:0] {
      FUNC_HEADER  = 2'd0,
      FUNC_DATA    = 2'd1,
      FUNC_SAVE    = 2'd2,
      FUNC_RESTORE = 2'd3
   } ttad_func_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_FIRST_TAP  = 1'b0,
      CSR_SECOND_TAP = 1'b1
   } ttad_csr_type;

   // Update command from the sequencer to the channel state
   typedef struct packed {
      logic                       hdr_wr;
      logic                       smp_wr;
      logic                       save;
      logic                       restore;
      logic [CHAN_W-1:0]          chan;
      logic [3:0]                 shift;
      logic [3:0]                 filt;
      logic signed [SAMPLE_W-1:0] sample;
   } ttad_st_cmd_type;

   // Current state of the selected channel
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] newest;
      logic signed [SAMPLE_W-1:0] older;
      logic [3:0]                 shift;
      logic [3:0]                 filt;
   } ttad_st_view_type;

   // Pick coefficient k out of a packed table
   function automatic logic signed [TAP_W-1:0] tap_coef(input logic [TABLE_W-1:0] tbl,
                                                        input logic [2:0] k);
      logic signed [TAP_W-1:0] c;
      unique case (k)
         3'd0:    c = tbl[0*TAP_W +: TAP_W];
         3'd1:    c = tbl[1*TAP_W +: TAP_W];
         3'd2:    c = tbl[2*TAP_W +: TAP_W];
         3'd3:    c = tbl[3*TAP_W +: TAP_W];
         3'd4:    c = tbl[4*TAP_W +: TAP_W];
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

@@ design/ttad_predictor.sv @@
// ----------------------------------------------------------------------------
// ttad_predictor
// One ADPCM sample: scaled nibble plus two-tap prediction, saturated.
// ----------------------------------------------------------------------------
module ttad_predictor
   import ttad_pkg::*;
(
   input  logic [3:0]                 nibble,
   input  logic [3:0]                 shift,
   input  logic [2:0]                 filt,
   input  logic signed [SAMPLE_W-1:0] newest,
   input  logic signed [SAMPLE_W-1:0] older,
   input  logic [TABLE_W-1:0]         first_tap,
   input  logic [TABLE_W-1:0]         second_tap,
   output logic signed [SAMPLE_W-1:0] sample
);

   logic signed [TAP_W-1:0]    c0;
   logic signed [TAP_W-1:0]    c1;
   logic signed [SAMPLE_W-1:0] nib_ext;
   logic signed [SAMPLE_W-1:0] scaled;
   logic signed [27:0]         prod0;
   logic signed [27:0]         prod1;
   logic signed [28:0]         psum;
   logic signed [20:0]         pshift;
   logic                       round_up;
   logic signed [20:0]         pred;
   logic signed [21:0]         total;

   assign c0 = tap_coef(first_tap, filt);
   assign c1 = tap_coef(second_tap, filt);

   // Sign-extended nibble times 2^shift; shift is at most 12 so it fits
   assign nib_ext = {{(SAMPLE_W-4){nibble[3]}}, nibble};
   assign scaled  = nib_ext <<< shift;

   // Prediction, divided by 256 with truncation toward zero
   assign prod0    = newest * c0;
   assign prod1    = older * c1;
   assign psum     = 29'(prod0) + 29'(prod1);
   assign pshift   = psum[28:8];
   assign round_up = psum[28] & (|psum[7:0]);
   assign pred     = pshift + $signed({20'd0, round_up});

   // Sum and clamp to int16
   assign total = 22'(scaled) + 22'(pred);

   always_comb begin
      if (total > 22'sd32767) begin
         sample = 16'sh7FFF;
      end else if (total < -22'sd32768) begin
         sample = -16'sh8000;
      end else begin
         sample = total[SAMPLE_W-1:0];
      end
   end

endmodule

@@ design/ttad_chan_state.sv @@
// ----------------------------------------------------------------------------
// ttad_chan_state
// Per-channel history, shift and filter, with the loop snapshot copy.
// ----------------------------------------------------------------------------
module ttad_chan_state
   import ttad_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ttad_st_cmd_type  cmd,
   input  logic [CHAN_W-1:0] rd_chan,
   output ttad_st_view_type view
);

   logic signed [SAMPLE_W-1:0] newest_ff [CHANNELS];
   logic signed [SAMPLE_W-1:0] older_ff  [CHANNELS];
   logic signed [SAMPLE_W-1:0] saved_newest_ff [CHANNELS];
   logic signed [SAMPLE_W-1:0] saved_older_ff  [CHANNELS];
   logic [3:0]                 shift_ff  [CHANNELS];
   logic [3:0]                 filt_ff   [CHANNELS];

   // State updates; only one command is active in a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            newest_ff[i]       <= '0;
            older_ff[i]        <= '0;
            saved_newest_ff[i] <= '0;
            saved_older_ff[i]  <= '0;
            shift_ff[i]        <= '0;
            filt_ff[i]         <= '0;
         end
      end else begin
         if (cmd.hdr_wr) begin
            shift_ff[cmd.chan] <= cmd.shift;
            filt_ff[cmd.chan]  <= cmd.filt;
         end
         if (cmd.smp_wr) begin
            older_ff[cmd.chan]  <= newest_ff[cmd.chan];
            newest_ff[cmd.chan] <= cmd.sample;
         end
         if (cmd.save) begin
            for (int i = 0; i < CHANNELS; i++) begin
               saved_newest_ff[i] <= newest_ff[i];
               saved_older_ff[i]  <= older_ff[i];
            end
         end
         if (cmd.restore) begin
            for (int i = 0; i < CHANNELS; i++) begin
               newest_ff[i] <= saved_newest_ff[i];
               older_ff[i]  <= saved_older_ff[i];
            end
         end
      end
   end

   // Selected channel view
   assign view.newest = newest_ff[rd_chan];
   assign view.older  = older_ff[rd_chan];
   assign view.shift  = shift_ff[rd_chan];
   assign view.filt   = filt_ff[rd_chan];

endmodule

@@ design/two_tap_adpcm_block_decoder_top.sv @@
// ----------------------------------------------------------------------------
// two_tap_adpcm_block_decoder_top
// Multi-channel two-tap ADPCM decoder with loop snapshot support.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries commands: header byte, data byte, save or restore snapshot.
//   rsp_* carries decoded 16-bit samples; tlast marks the high-nibble sample.
//   csr_* writes the two packed coefficient tables, which the user must do
//   only while idle (not enforced by the block); csr_* is always ready.
// Sequencing:
//   A command is registered on acceptance. A data byte then stays in the
//   input register until both its samples are made, low nibble first,
//   because the second sample feeds on the first through the channel
//   history; each sample is held in the output register that drives rsp_.
//   Header, save and restore commands and data bytes with a filter of 5 or
//   more produce nothing. The input register takes a new command in the
//   cycle the current one finishes, so commands stream without bubbles.
// Reset:
//   Synchronous reset clears history, shift, filter, snapshot and tables.
// Stall:
//   A stalled rsp_ holds its sample; the sample unit and then req_tready wait.
// ----------------------------------------------------------------------------
module two_tap_adpcm_block_decoder_top
   import ttad_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Commands
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,  // func[1:0], chan[4:2], in_byte[12:5], zero
   // Samples
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,  // pcm_sample[15:0], sample_chan[18:16], zero
   output logic                 rsp_tlast,  // last_of_byte
   // Configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [TABLE_W-1:0]   csr_data
);

   // Input register
   logic                 in_valid_ff, in_valid_in;
   ttad_func_type        in_func_ff;
   logic [CHAN_W-1:0]    in_chan_ff;
   logic [7:0]           in_byte_ff;
   logic                 phase_ff, phase_in;

   // Coefficient tables
   logic [TABLE_W-1:0]   first_tap_ff;
   logic [TABLE_W-1:0]   second_tap_ff;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic [CHAN_W-1:0]    rsp_chan_ff;
   logic                 rsp_last_ff;

   ttad_st_cmd_type      cmd;
   ttad_st_view_type     view;
   logic                 chan_ok;
   logic                 emits;
   logic                 out_free;
   logic                 fire;
   logic                 in_done;
   logic                 req_acc;
   logic [3:0]           nibble;
   logic [3:0]           hdr_lo;
   logic signed [SAMPLE_W-1:0] sample;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_tap_ff  <= '0;
         second_tap_ff <= '0;
      end else if (csr_valid) begin
         unique case (ttad_csr_type'(csr_index))
            CSR_FIRST_TAP:  first_tap_ff  <= csr_data;
            CSR_SECOND_TAP: second_tap_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencing of the held command
   assign chan_ok  = 32'(in_chan_ff) < CHANNELS;
   assign emits    = in_valid_ff && (in_func_ff == FUNC_DATA) && chan_ok
                     && (view.filt < 4'(NUM_FILT));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire     = emits && out_free;
   assign in_done  = in_valid_ff && (!emits || (out_free && phase_ff));
   assign req_tready = !in_valid_ff || in_done;
   assign req_acc  = req_tvalid && req_tready;

   assign in_valid_in = req_acc ? 1'b1 : (in_done ? 1'b0 : in_valid_ff);
   assign phase_in    = fire ? ~phase_ff : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_func_ff <= ttad_func_type'(req_tdata[1:0]);
         in_chan_ff <= req_tdata[4:2];
         in_byte_ff <= req_tdata[12:5];
      end
   end

   // Channel state
   assign hdr_lo = in_byte_ff[3:0];

   always_comb begin
      cmd         = '0;
      cmd.chan    = in_chan_ff;
      cmd.hdr_wr  = in_valid_ff && (in_func_ff == FUNC_HEADER) && chan_ok;
      cmd.save    = in_valid_ff && (in_func_ff == FUNC_SAVE);
      cmd.restore = in_valid_ff && (in_func_ff == FUNC_RESTORE);
      cmd.smp_wr  = fire;
      cmd.shift   = (hdr_lo > SHIFT_BASE) ? 4'd0 : (SHIFT_BASE - hdr_lo);
      cmd.filt    = in_byte_ff[7:4];
      cmd.sample  = sample;
   end

   ttad_chan_state u_state (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_chan (in_chan_ff),
      .view    (view)
   );

   // Sample unit, low nibble first
   assign nibble = phase_ff ? in_byte_ff[7:4] : in_byte_ff[3:0];

   ttad_predictor u_pred (
      .nibble     (nibble),
      .shift      (view.shift),
      .filt       (view.filt[2:0]),
      .newest     (view.newest),
      .older      (view.older),
      .first_tap  (first_tap_ff),
      .second_tap (second_tap_ff),
      .sample     (sample)
   );

   // Output register
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_sample_ff <= sample;
         rsp_chan_ff   <= in_chan_ff;
         rsp_last_ff   <= phase_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_chan_ff, rsp_sample_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-tap ADPCM block decoder. A directed table
// walks reset behavior, shift clamping, dead filters, snapshots and tap
// extremes. Random header/data runs follow under six coefficient settings.
// Every sample is checked against an in-bench decoder model or a typed value.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ttad_pkg::*;

   localparam int IDLE_PCT       = 36;
   localparam int PHASE_ITEMS    = 135;
   localparam int NUM_PHASES     = 6;
   localparam int REPORT_MAX     = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]          chan;
      logic                       last;
   } pcm_result_type;

   typedef enum logic {ROW_CMD, ROW_TAPS} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      ttad_func_type              func;
      logic [CHAN_W-1:0]          chan;
      logic [7:0]                 in_byte;
      bit                         typed;
      int                         n_typed;
      logic signed [SAMPLE_W-1:0] lo_sample;
      logic signed [SAMPLE_W-1:0] hi_sample;
      logic [TABLE_W-1:0]         c0_table;
      logic [TABLE_W-1:0]         c1_table;
   } stim_row_type;

   // DUT signals
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic                csr_index  = 1'b0;
   logic [TABLE_W-1:0]  csr_data   = '0;

   // Decoder model state
   logic signed [SAMPLE_W-1:0] newest_mem  [CHANNELS];
   logic signed [SAMPLE_W-1:0] older_mem   [CHANNELS];
   logic signed [SAMPLE_W-1:0] snap_newest [CHANNELS];
   logic signed [SAMPLE_W-1:0] snap_older  [CHANNELS];
   logic [3:0]                 shift_mem   [CHANNELS];
   logic [3:0]                 filter_mem  [CHANNELS];
   logic [TABLE_W-1:0]         first_taps;
   logic [TABLE_W-1:0]         second_taps;

   pcm_result_type pcm_expected[$];
   stim_row_type   dir_rows[$];
   int             fault_count  = 0;
   int             quiet_cycles = 0;
   bit             steady_flow  = 1'b0;

   two_tap_adpcm_block_decoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample receiver backpressure
   always @(posedge clock) begin
      if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Watchdog: no transaction on any channel for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[two_tap_adpcm_block_decoder_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void note_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_MAX) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
   endfunction

   // Append one expected sample to the scoreboard
   function automatic void queue_sample(input pcm_result_type r);
      pcm_expected.insert(pcm_expected.size(), r);
   endfunction

   // Append one row to the directed table
   function automatic void add_row(input stim_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   function automatic logic [TABLE_W-1:0] pack_taps(input int k0, input int k1, input int k2,
                                                    input int k3, input int k4);
      return {12'(k4), 12'(k3), 12'(k2), 12'(k1), 12'(k0)};
   endfunction

   // One nibble through the channel's two-tap predictor; history shifts
   function automatic logic signed [SAMPLE_W-1:0] decode_nibble(input logic [CHAN_W-1:0] ch,
                                                                input logic [3:0] nib);
      int          v;
      int          pred;
      int          c0;
      int          c1;
      logic [3:0]  f;
      logic signed [TAP_W-1:0] t0;
      logic signed [TAP_W-1:0] t1;
      f    = filter_mem[ch];
      t0   = first_taps[TAP_W*f +: TAP_W];
      t1   = second_taps[TAP_W*f +: TAP_W];
      c0   = t0;
      c1   = t1;
      v    = $signed(nib);
      v    = v * (1 << shift_mem[ch]);
      pred = newest_mem[ch] * c0 + older_mem[ch] * c1;
      v    = v + pred / 256;   // truncates toward zero
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      older_mem[ch]  = newest_mem[ch];
      newest_mem[ch] = 16'(v);
      return 16'(v);
   endfunction

   // Apply one command to the model; returns the number of samples produced
   function automatic int decode_command(input ttad_func_type f, input logic [CHAN_W-1:0] ch,
                                         input logic [7:0] b,
                                         output pcm_result_type r0, output pcm_result_type r1);
      r0 = '0;
      r1 = '0;
      case (f)
         FUNC_SAVE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               snap_newest[i] = newest_mem[i];
               snap_older[i]  = older_mem[i];
            end
            return 0;
         end
         FUNC_RESTORE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               newest_mem[i] = snap_newest[i];
               older_mem[i]  = snap_older[i];
            end
            return 0;
         end
         FUNC_HEADER: begin
            shift_mem[ch]  = (b[3:0] > SHIFT_BASE) ? 4'd0 : SHIFT_BASE - b[3:0];
            filter_mem[ch] = b[7:4];
            return 0;
         end
         default: begin
            if (filter_mem[ch] >= NUM_FILT) return 0;
            r0 = '{decode_nibble(ch, b[3:0]), ch, 1'b0};
            r1 = '{decode_nibble(ch, b[7:4]), ch, 1'b1};
            return 2;
         end
      endcase
   endfunction

   function automatic stim_row_type plain_row(input ttad_func_type f,
                                              input logic [CHAN_W-1:0] ch,
                                              input logic [7:0] b);
      stim_row_type row;
      row = '{kind: ROW_CMD, func: f, chan: ch, in_byte: b, typed: 1'b0, n_typed: 0,
              lo_sample: '0, hi_sample: '0, c0_table: '0, c1_table: '0};
      return row;
   endfunction

   function automatic stim_row_type typed_row(input ttad_func_type f,
                                              input logic [CHAN_W-1:0] ch,
                                              input logic [7:0] b, input int n,
                                              input int lo, input int hi);
      stim_row_type row;
      row           = plain_row(f, ch, b);
      row.typed     = 1'b1;
      row.n_typed   = n;
      row.lo_sample = 16'(lo);
      row.hi_sample = 16'(hi);
      return row;
   endfunction

   function automatic stim_row_type taps_row(input logic [TABLE_W-1:0] c0,
                                             input logic [TABLE_W-1:0] c1);
      stim_row_type row;
      row          = plain_row(FUNC_HEADER, '0, '0);
      row.kind     = ROW_TAPS;
      row.c0_table = c0;
      row.c1_table = c1;
      return row;
   endfunction

   // Header byte: mostly a live filter, now and then a dead one
   function automatic logic [7:0] header_byte();
      logic [3:0] hi;
      if ($urandom_range(0, 99) < 85) begin
         hi = 4'($urandom_range(0, NUM_FILT - 1));
      end else begin
         hi = 4'($urandom_range(NUM_FILT, 15));
      end
      return {hi, 4'($urandom_range(0, 15))};
   endfunction

   // Stop sending and wait for every pending sample, then settle
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pcm_expected.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Write both coefficient tables while the decoder is idle
   task automatic load_taps(input logic [TABLE_W-1:0] c0, input logic [TABLE_W-1:0] c1);
      drain(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_TAP;
      csr_data  <= c0;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_SECOND_TAP;
      csr_data  <= c1;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      first_taps  = c0;
      second_taps = c1;
   endtask

   // Present one command; on acceptance record the samples it should produce
   task automatic send_item(input stim_row_type row);
      pcm_result_type r0;
      pcm_result_type r1;
      int             n;
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, row.in_byte, row.chan, row.func};
      do @(posedge clock); while (!req_tready);
      n = decode_command(row.func, row.chan, row.in_byte, r0, r1);
      if (row.typed) begin
         n  = row.n_typed;
         r0 = '{row.lo_sample, row.chan, 1'b0};
         r1 = '{row.hi_sample, row.chan, 1'b1};
      end
      if (n > 0) queue_sample(r0);
      if (n > 1) queue_sample(r1);
   endtask

   // Header-led runs of data bytes with some snapshot and cross-channel noise
   task automatic run_random(input int quota, input bit pause_midway);
      int                counted;
      int                run_len;
      int                r;
      logic [CHAN_W-1:0] ch;
      stim_row_type      row;
      counted = 0;
      while (counted < quota) begin
         if (pause_midway && counted >= quota / 2) begin
            drain(0);
            pause_midway = 1'b0;
         end
         ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
         send_item(plain_row(FUNC_HEADER, ch, header_byte()));
         counted++;
         run_len = $urandom_range(1, 14);
         for (int k = 0; k < run_len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               row = plain_row(FUNC_SAVE, CHAN_W'($urandom_range(0, CHANNELS - 1)),
                               8'($urandom_range(0, 255)));
            end else if (r < 8) begin
               row = plain_row(FUNC_RESTORE, CHAN_W'($urandom_range(0, CHANNELS - 1)),
                               8'($urandom_range(0, 255)));
            end else if (r < 11) begin
               row = plain_row(FUNC_HEADER, CHAN_W'($urandom_range(0, CHANNELS - 1)),
                               header_byte());
            end else if (r < 14) begin
               row = plain_row(FUNC_DATA, CHAN_W'($urandom_range(0, CHANNELS - 1)),
                               8'($urandom_range(0, 255)));
            end else begin
               row = plain_row(FUNC_DATA, ch, 8'($urandom_range(0, 255)));
            end
            counted++;
            send_item(row);
         end
      end
   endtask

   // Sample checker
   always @(posedge clock) begin
      pcm_result_type got;
      pcm_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[18:16], rsp_tlast};
         if (pcm_expected.size() == 0) begin
            note_fault($sformatf("unexpected sample %0d chan %0d last %0d",
                                 got.sample, got.chan, got.last));
         end else begin
            want = pcm_expected.pop_front();
            if (got != want) begin
               note_fault($sformatf("sample exp %0d got %0d, chan exp %0d got %0d, last exp %0d got %0d",
                                    want.sample, got.sample, want.chan, got.chan,
                                    want.last, got.last));
            end
         end
      end
   end

   // Main sequence
   initial begin
      logic [TABLE_W-1:0] phase_c0[NUM_PHASES];
      logic [TABLE_W-1:0] phase_c1[NUM_PHASES];

      for (int i = 0; i < CHANNELS; i++) begin
         newest_mem[i]  = '0;
         older_mem[i]   = '0;
         snap_newest[i] = '0;
         snap_older[i]  = '0;
         shift_mem[i]   = '0;
         filter_mem[i]  = '0;
      end
      first_taps  = '0;
      second_taps = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero taps after reset: samples are just the scaled nibbles
      add_row(typed_row(FUNC_DATA,    3'd0, 8'h87, 2, 7, -8));
      add_row(plain_row(FUNC_HEADER,  3'd0, 8'h00));
      add_row(typed_row(FUNC_DATA,    3'd0, 8'h78, 2, -32768, 28672));
      add_row(typed_row(FUNC_DATA,    3'd7, 8'hFF, 2, -1, -1));
      // low nibble above twelve clamps the shift to zero
      add_row(plain_row(FUNC_HEADER,  3'd7, 8'h0D));
      add_row(typed_row(FUNC_DATA,    3'd7, 8'h10, 2, 0, 1));
      // dead filters drop data bytes
      add_row(plain_row(FUNC_HEADER,  3'd3, 8'hFF));
      add_row(typed_row(FUNC_DATA,    3'd3, 8'hAB, 0, 0, 0));
      add_row(plain_row(FUNC_HEADER,  3'd3, 8'h54));
      add_row(typed_row(FUNC_DATA,    3'd3, 8'h33, 0, 0, 0));
      add_row(plain_row(FUNC_HEADER,  3'd3, 8'h4C));
      add_row(typed_row(FUNC_DATA,    3'd3, 8'h21, 2, 1, 2));
      add_row(plain_row(FUNC_SAVE,    3'd5, 8'hFF));
      add_row(plain_row(FUNC_RESTORE, 3'd2, 8'h00));
      // Classic filter set, snapshot around a detour
      add_row(taps_row(pack_taps(0, 240, 460, 392, 488),
                       pack_taps(0, 0, -208, -220, -240)));
      add_row(plain_row(FUNC_HEADER,  3'd1, 8'h1A));
      add_row(plain_row(FUNC_DATA,    3'd1, 8'h77));
      add_row(plain_row(FUNC_DATA,    3'd1, 8'h19));
      add_row(plain_row(FUNC_SAVE,    3'd0, 8'h00));
      add_row(plain_row(FUNC_DATA,    3'd1, 8'h9E));
      add_row(plain_row(FUNC_RESTORE, 3'd0, 8'h00));
      add_row(plain_row(FUNC_DATA,    3'd1, 8'h00));
      // Largest positive taps drive the output into saturation
      add_row(taps_row({NUM_FILT{12'h7FF}}, {NUM_FILT{12'h7FF}}));
      add_row(plain_row(FUNC_HEADER,  3'd2, 8'h00));
      add_row(plain_row(FUNC_DATA,    3'd2, 8'h77));
      add_row(plain_row(FUNC_DATA,    3'd2, 8'h88));
      // Most negative taps
      add_row(taps_row({NUM_FILT{12'h800}}, {NUM_FILT{12'h800}}));
      add_row(plain_row(FUNC_DATA,    3'd2, 8'h77));
      add_row(plain_row(FUNC_DATA,    3'd2, 8'h80));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_TAPS) begin
            load_taps(dir_rows[i].c0_table, dir_rows[i].c1_table);
         end else begin
            send_item(dir_rows[i]);
         end
      end

      // Coefficient settings for the random phases
      phase_c0[0] = pack_taps(0, 240, 460, 392, 488);
      phase_c1[0] = pack_taps(0, 0, -208, -220, -240);
      phase_c0[1] = {NUM_FILT{12'h7FF}};
      phase_c1[1] = {NUM_FILT{12'h7FF}};
      phase_c0[2] = {NUM_FILT{12'h800}};
      phase_c1[2] = {NUM_FILT{12'h800}};
      phase_c0[3] = '1;
      phase_c1[3] = '0;
      phase_c0[4] = TABLE_W'({$urandom, $urandom});
      phase_c1[4] = TABLE_W'({$urandom, $urandom});
      phase_c0[5] = '0;
      phase_c1[5] = '1;

      for (int p = 0; p < NUM_PHASES; p++) begin
         load_taps(phase_c0[p], phase_c1[p]);
         steady_flow = (p == 1);   // one phase with no idling on either side
         run_random(PHASE_ITEMS, p == 2);
      end
      steady_flow = 1'b0;

      drain(END_CYCLES);
      if (pcm_expected.size() != 0) begin
         note_fault($sformatf("%0d samples never arrived", pcm_expected.size()));
      end
      if (fault_count == 0) begin
         $display("[two_tap_adpcm_block_decoder_top] OK");
      end else begin
         $display("[two_tap_adpcm_block_decoder_top] ERROR");
      end
      $finish;
   end

endmodule
